### rtl/core/utf8_line_wrapper_top_defines.svh
// ----------------------------------------------------------------------------
// UTF-8 line wrapper assertion macros
// Concurrent check wrappers; they expand to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef UTF8_LINE_WRAPPER_TOP_DEFINES_SVH
`define UTF8_LINE_WRAPPER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on clk, off while arst_n is low
`define ULW_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("utf8_line_wrapper: same-cycle check failed");

// next-cycle implication
`define ULW_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("utf8_line_wrapper: next-cycle check failed");

`else

`define ULW_ASSERT_NOW(label, ante, cons)
`define ULW_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### rtl/core/ulw_pkg.sv
// ----------------------------------------------------------------------------
// ulw_pkg
// Shared types and constants of the UTF-8 line wrapper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ulw_pkg;

	// register indexes of the configuration port
	typedef enum logic [1:0] {
		REG_CHARS_PER_LINE = 2'd0,
		REG_LINE_LIMIT     = 2'd1
	} reg_idx_t;

	localparam logic [7:0] CHARS_PER_LINE_RST = 8'd22;
	localparam logic [7:0] LINE_LIMIT_RST     = 8'd0;

	// lead byte classes
	localparam logic [7:0] MASK_1B  = 8'h80;
	localparam logic [7:0] MASK_2B  = 8'hE0;
	localparam logic [7:0] LEAD_2B  = 8'hC0;
	localparam logic [7:0] MASK_3B  = 8'hF0;
	localparam logic [7:0] LEAD_3B  = 8'hE0;
	localparam logic [7:0] MASK_4B  = 8'hF8;
	localparam logic [7:0] LEAD_4B  = 8'hF0;
	localparam logic [7:0] NEWLINE  = 8'h0A;

	// input item
	typedef struct packed {
		logic [7:0] text_byte;
		logic       final_byte;
	} in_item_t;

	// result item
	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic       line_end;
		logic       text_done;
		logic       run_last;
	} out_item_t;

	// configuration write request
	typedef struct packed {
		logic [1:0] index;
		logic [7:0] data;
	} cfg_req_t;

	// configuration register file contents
	typedef struct packed {
		logic [7:0] chars_per_line;
		logic [7:0] line_limit;
	} cfg_t;

	// one classified item as queued between front and back
	typedef struct packed {
		logic [3:0][7:0] bytes;      // bytes in text order, index 0 first
		logic [1:0]      last_idx;   // index of the last byte in use
		logic [3:0]      char_end;   // byte closes a character
		logic [3:0]      newline;    // byte is a lone newline character
		logic            final_flag; // item carried the last byte of the text
	} work_t;

	// back-end line state, for checks
	typedef struct packed {
		logic line_nonempty;
		logic limit_reached;
	} status_t;

	// character length from a lead byte; anything unexpected counts as one
	function automatic logic [2:0] lead_len(input logic [7:0] b);
		logic [2:0] len;
		if ((b & MASK_1B) == 8'h00)         len = 3'd1;
		else if ((b & MASK_2B) == LEAD_2B) len = 3'd2;
		else if ((b & MASK_3B) == LEAD_3B) len = 3'd3;
		else if ((b & MASK_4B) == LEAD_4B) len = 3'd4;
		else                               len = 3'd1;
		return len;
	endfunction

endpackage

`default_nettype wire

### rtl/core/ulw_stream_if.sv
// ----------------------------------------------------------------------------
// ulw_stream_if
// Valid/ready channel carrying one payload struct per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ulw_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/core/utf8_line_wrapper_top.sv
// The first result of an item passes through a queue entry and the result register before it shows on result_out.
// Bytes are taken while the queue has room, even as the back end works on older items.
// The back end steps once per queued byte, plus once for the end-of-text marker of a final item.
// The queue between front and back end is QUEUE_DEPTH entries deep.
// Reset: arst_n clears all control state; chars_per_line returns to 22, line_limit to 0.
// ----------------------------------------------------------------------------
// utf8_line_wrapper_top
// UTF-8 aware line wrapper: front end assembles characters, back end places
// them into lines and emits bytes marked with line ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_line_wrapper_top_defines.svh"

module utf8_line_wrapper_top #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	ulw_stream_if.sink    text_in,
	ulw_stream_if.source  result_out,
	ulw_stream_if.sink    cfg_wr
);
	ulw_pkg::cfg_t    cfg_q;
	ulw_pkg::work_t   push_data;
	ulw_pkg::work_t   head_data;
	ulw_pkg::status_t status;
	logic             push_valid;
	logic             push_ready;
	logic             head_valid;
	logic             pop;

	// configuration registers, always ready
	assign cfg_wr.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.chars_per_line <= ulw_pkg::CHARS_PER_LINE_RST;
			cfg_q.line_limit     <= ulw_pkg::LINE_LIMIT_RST;
		end else if (cfg_wr.valid) begin
			case (cfg_wr.payload.index)
				ulw_pkg::REG_CHARS_PER_LINE: cfg_q.chars_per_line <= cfg_wr.payload.data;
				ulw_pkg::REG_LINE_LIMIT:     cfg_q.line_limit     <= cfg_wr.payload.data;
				default: ;
			endcase
		end
	end

	// character assembly
	ulw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_in    (text_in),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready)
	);

	// decoupling queue
	ulw_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop        (pop),
		.head_valid (head_valid),
		.head_data  (head_data)
	);

	// line placement and results
	ulw_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head_data  (head_data),
		.pop        (pop),
		.result_out (result_out),
		.status     (status)
	);

	// a shown line end leaves the line empty
	`ULW_ASSERT_NOW(a_line_end_empties, result_out.valid && result_out.payload.line_end, !status.line_nonempty)
	// the end-of-text marker leaves the text state cleared
	`ULW_ASSERT_NOW(a_done_clears, result_out.valid && result_out.payload.text_done, !status.limit_reached && !status.line_nonempty)
	// the line limit only trips together with a closing line
	`ULW_ASSERT_NOW(a_limit_on_close, $rose(status.limit_reached), result_out.valid && result_out.payload.line_end)
	// line state holds while the result register is stalled
	`ULW_ASSERT_NEXT(a_hold_on_stall, result_out.valid && !result_out.ready, $stable(status))

endmodule

`default_nettype wire

### rtl/core/ulw_queue.sv
// ----------------------------------------------------------------------------
// ulw_queue
// Small FIFO of classified items between the front and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ulw_queue #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	input  ulw_pkg::work_t  push_data,
	output logic            push_ready,
	input  logic            pop,
	output logic            head_valid,
	output ulw_pkg::work_t  head_data
);
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	ulw_pkg::work_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && head_valid;

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/core/ulw_front.sv
// ----------------------------------------------------------------------------
// ulw_front
// Takes text bytes, assembles UTF-8 characters and queues classified items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ulw_front (
	input  logic            clk,
	input  logic            arst_n,
	ulw_stream_if.sink      text_in,
	output logic            push_valid,
	output ulw_pkg::work_t  push_data,
	input  logic            push_ready
);
	logic [7:0] held_q [3];
	logic [1:0] held_count_q;
	logic [2:0] expected_q;

	logic [7:0]      in_byte;
	logic            in_final;
	logic            accept;
	logic [2:0]      in_len;
	logic            completes;
	logic [3:0][7:0] buf_bytes;
	logic [3:0]      fin_end;
	logic [3:0]      fin_nl;

	assign in_byte  = text_in.payload.text_byte;
	assign in_final = text_in.payload.final_byte;
	assign text_in.ready = push_ready;
	assign accept   = text_in.valid && push_ready;
	assign in_len   = ulw_pkg::lead_len(in_byte);
	// a held character gets its last byte
	assign completes = (held_count_q != 2'd0) &&
		(({1'b0, held_count_q} + 3'd1) >= expected_q);

	// held bytes followed by the new byte
	always_comb begin
		buf_bytes = '0;
		for (int i = 0; i < 3; i++) begin
			if (2'(i) < held_count_q) begin
				buf_bytes[i] = held_q[i];
			end
		end
		buf_bytes[held_count_q] = in_byte;
	end

	// end of text: split the held bytes and the last byte into characters again
	always_comb begin
		logic [2:0] p;
		logic [2:0] len;
		logic [2:0] n;
		logic [2:0] e;
		fin_end = '0;
		fin_nl  = '0;
		p   = 3'd0;
		len = 3'd0;
		e   = 3'd0;
		n = {1'b0, held_count_q} + 3'd1;
		for (int i = 0; i < 4; i++) begin
			if (3'(i) == p && 3'(i) < n) begin
				len = ulw_pkg::lead_len(buf_bytes[i]);
				if (p + len > n) begin
					len = 3'd1;
				end
				e = p + len - 3'd1;
				fin_end[e[1:0]] = 1'b1;
				fin_nl[i] = (len == 3'd1) && (buf_bytes[i] == ulw_pkg::NEWLINE);
				p = p + len;
			end
		end
	end

	// queued record
	always_comb begin
		push_data.bytes      = buf_bytes;
		push_data.last_idx   = held_count_q;
		push_data.final_flag = in_final;
		if (in_final) begin
			push_data.char_end = fin_end;
			push_data.newline  = fin_nl;
		end else begin
			push_data.char_end = 4'b0001 << held_count_q;
			push_data.newline  = {3'b000,
				(held_count_q == 2'd0) && (in_byte == ulw_pkg::NEWLINE)};
		end
		push_valid = accept && (in_final || completes ||
			(held_count_q == 2'd0 && in_len == 3'd1));
	end

	// held byte storage
	always_ff @(posedge clk) begin
		if (accept && !in_final) begin
			if (held_count_q == 2'd0) begin
				held_q[0] <= in_byte;
			end else if (!completes) begin
				held_q[held_count_q] <= in_byte;
			end
		end
	end

	// character assembly state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count_q <= 2'd0;
			expected_q   <= 3'd0;
		end else if (accept) begin
			if (in_final || completes) begin
				held_count_q <= 2'd0;
				expected_q   <= 3'd0;
			end else if (held_count_q == 2'd0) begin
				if (in_len != 3'd1) begin
					held_count_q <= 2'd1;
					expected_q   <= in_len;
				end
			end else begin
				held_count_q <= held_count_q + 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/core/ulw_back.sv
// ----------------------------------------------------------------------------
// ulw_back
// Steps through queued items byte by byte, counts characters and lines, and
// drives the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ulw_back (
	input  logic               clk,
	input  logic               arst_n,
	input  ulw_pkg::cfg_t      cfg,
	input  logic               head_valid,
	input  ulw_pkg::work_t     head_data,
	output logic               pop,
	ulw_stream_if.source       result_out,
	output ulw_pkg::status_t   status
);
	logic [1:0] idx_q;
	logic       done_phase_q;
	logic [7:0] chars_q;
	logic [7:0] lines_q;
	logic       nonempty_q;
	logic       limit_q;
	logic       out_valid_q;
	ulw_pkg::out_item_t out_q;

	logic [7:0] chars_d;
	logic [7:0] lines_d;
	logic       nonempty_d;
	logic       limit_d;
	logic       res_valid;
	ulw_pkg::out_item_t res;
	logic       advance;
	logic       is_last;
	logic [7:0] lim;
	logic       line_full;
	logic [7:0] lines_inc;
	logic [7:0] cur_byte;
	logic       cur_nl;
	logic       cur_end;

	assign result_out.valid   = out_valid_q;
	assign result_out.payload = out_q;
	assign status.line_nonempty = nonempty_q;
	assign status.limit_reached = limit_q;

	// one step per cycle while the result register is free or draining
	assign advance = head_valid && (!out_valid_q || result_out.ready);
	assign is_last = (idx_q == head_data.last_idx);
	assign pop     = advance && (done_phase_q || (is_last && !head_data.final_flag));

	assign cur_byte  = head_data.bytes[idx_q];
	assign cur_nl    = head_data.newline[idx_q];
	assign cur_end   = head_data.char_end[idx_q];
	assign lim       = (cfg.chars_per_line == 8'd0) ? 8'd1 : cfg.chars_per_line;
	assign line_full = ({1'b0, chars_q} + 9'd1) >= {1'b0, lim};
	assign lines_inc = (lines_q == 8'hFF) ? lines_q : lines_q + 8'd1;

	// result and next line state for the current step
	always_comb begin
		logic close;
		close      = 1'b0;
		res        = '0;
		res_valid  = 1'b0;
		chars_d    = chars_q;
		lines_d    = lines_q;
		nonempty_d = nonempty_q;
		limit_d    = limit_q;
		if (done_phase_q) begin
			// end-of-text marker, closes a non-empty tail, then text state clears
			res_valid     = 1'b1;
			res.line_end  = !limit_q && nonempty_q;
			res.text_done = 1'b1;
			res.run_last  = 1'b1;
			chars_d    = 8'd0;
			lines_d    = 8'd0;
			nonempty_d = 1'b0;
			limit_d    = 1'b0;
		end else if (!limit_q) begin
			close         = cur_nl || (cur_end && line_full);
			res_valid     = 1'b1;
			res.has_byte  = !cur_nl;
			res.out_byte  = cur_nl ? 8'd0 : cur_byte;
			res.line_end  = close;
			res.run_last  = !head_data.final_flag && is_last;
			if (close) begin
				chars_d    = 8'd0;
				nonempty_d = 1'b0;
				lines_d    = lines_inc;
				limit_d    = (cfg.line_limit != 8'd0) && (lines_inc >= cfg.line_limit);
			end else if (cur_end) begin
				chars_d    = chars_q + 8'd1;
				nonempty_d = 1'b1;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_q <= res;
		end
	end

	// step sequencer, line state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= 2'd0;
			done_phase_q <= 1'b0;
			chars_q      <= 8'd0;
			lines_q      <= 8'd0;
			nonempty_q   <= 1'b0;
			limit_q      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (advance) begin
				chars_q    <= chars_d;
				lines_q    <= lines_d;
				nonempty_q <= nonempty_d;
				limit_q    <= limit_d;
				if (done_phase_q) begin
					done_phase_q <= 1'b0;
					idx_q        <= 2'd0;
				end else if (is_last) begin
					idx_q        <= 2'd0;
					done_phase_q <= head_data.final_flag;
				end else begin
					idx_q <= idx_q + 2'd1;
				end
			end
			if (advance && res_valid) begin
				out_valid_q <= 1'b1;
			end else if (result_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire
